FILE: sv/llts_pkg.sv
// ----------------------------------------------------------------------------
// llts_pkg: shared types and constants of the light level tick supervisor
// Item structs, shared unit request and response, register indexes.
// ----------------------------------------------------------------------------
package llts_pkg;

  localparam logic [7:0] TURBO_MARK = 8'hf0;
  localparam logic [7:0] FULL_LEVEL = 8'hff;
  localparam logic [7:0] TICK_MAX   = 8'hff;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TURBO_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPDOWN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURBO_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_THR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RUN_LIMIT = 3'd7;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [3:0] mode_index;
    logic [7:0] nominal_level;
    logic [7:0] battery_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] drive_level;
    logic       store_valid;
    logic [7:0] store_value;
    logic       blank;
    logic       shut_off;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ALU_CMP,
    ALU_DEC,
    ALU_HALF
  } alu_op_e;

  typedef struct packed {
    alu_op_e    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic       lt;
    logic       eq;
  } alu_rsp_t;

endpackage

FILE: sv/llts_alu.sv
// ----------------------------------------------------------------------------
// llts_alu: shared compare and level unit
// Compares a against b and forms a decremented or halved copy of a.
// ----------------------------------------------------------------------------
module llts_alu (
  input  llts_pkg::alu_req_t req_i,
  output llts_pkg::alu_rsp_t rsp_o
);
  import llts_pkg::*;

  logic [7:0] res;

  always_comb begin
    case (req_i.op)
      ALU_DEC:  res = req_i.a - 8'd1;
      ALU_HALF: res = {1'b0, req_i.a[7:1]};
      ALU_CMP:  res = req_i.a;
      default:  res = req_i.a;
    endcase
  end

  assign rsp_o.res = res;
  assign rsp_o.lt  = req_i.a < req_i.b;
  assign rsp_o.eq  = req_i.a == req_i.b;

endmodule

FILE: sv/light_level_tick_supervisor_unit.sv
// ----------------------------------------------------------------------------
// light_level_tick_supervisor_unit: drive level supervisor, top level
// Each accepted item runs through a sequence of states; after a turbo timeout
// a tick also ramps the level down one step at a time. Each sequencer step
// uses the one shared compare unit. The final result is registered as the
// sequencer returns to idle, where the next item can be taken; output stalls
// hold the output states. Reset (asynchronous, active low) clears all state
// and loads register defaults.
// ----------------------------------------------------------------------------
module light_level_tick_supervisor_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  llts_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output llts_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [llts_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [llts_pkg::CFG_DAT_W-1:0]      cfg_data_i
);
  import llts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_HALTED, S_TICK, S_STORE, S_TOUT, S_TURBO, S_TMARK,
    S_RAMP, S_LOW, S_RUN, S_HALF, S_CLAMP, S_OFF, S_FINAL
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] turbo_lvl_q, stepdown_q, store_dly_q, turbo_tout_q;
  logic [7:0] low_thr_q, crit_thr_q, min_lvl_q;
  logic [3:0] run_limit_q;
  logic [7:0] tick_q, tick_d;
  logic [3:0] low_run_q, low_run_d;
  logic       at_min_q, at_min_d;
  logic [7:0] cur_q, cur_d;
  logic [7:0] chosen_lvl_q, chosen_lvl_d;
  logic [3:0] chosen_idx_q, chosen_idx_d;
  logic       halted_q, halted_d;
  logic [7:0] sample_q, sample_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q, out_item_d;

  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;
  logic       slot_free;
  logic       in_acc;

  llts_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = state_q != S_IDLE;
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    low_run_d    = low_run_q;
    at_min_d     = at_min_q;
    cur_d        = cur_q;
    chosen_lvl_d = chosen_lvl_q;
    chosen_idx_d = chosen_idx_q;
    halted_d     = halted_q;
    sample_d     = sample_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_item_d   = out_item_q;
    alu_req      = '{op: ALU_CMP, a: cur_q, b: min_lvl_q};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item_i.command == CMD_START) begin
            chosen_idx_d = in_item_i.mode_index;
            chosen_lvl_d = in_item_i.nominal_level;
            tick_d       = 8'd0;
            low_run_d    = 4'd0;
            at_min_d     = 1'b0;
            halted_d     = 1'b0;
            state_d      = S_START;
          end else if (halted_q) begin
            state_d = S_HALTED;
          end else begin
            sample_d = in_item_i.battery_sample;
            if (tick_q != TICK_MAX) tick_d = tick_q + 8'd1;
            state_d = S_TICK;
          end
        end
      end
      S_START: begin
        alu_req = '{op: ALU_CMP, a: chosen_lvl_q, b: min_lvl_q};
        if (slot_free) begin
          cur_d       = alu_rsp.lt ? FULL_LEVEL : chosen_lvl_q;
          out_valid_d = 1'b1;
          out_item_d  = '{drive_level: cur_d, store_valid: 1'b0, store_value: 8'd0,
                          blank: 1'b0, shut_off: 1'b0, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_HALTED: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '{drive_level: 8'd0, store_valid: 1'b0, store_value: 8'd0,
                          blank: 1'b0, shut_off: 1'b0, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_TICK: begin
        alu_req = '{op: ALU_CMP, a: tick_q, b: store_dly_q};
        state_d = alu_rsp.eq ? S_STORE : S_TOUT;
      end
      S_STORE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '{drive_level: cur_q, store_valid: 1'b1,
                          store_value: {4'd0, chosen_idx_q},
                          blank: 1'b0, shut_off: 1'b0, last: 1'b0};
          state_d     = S_LOW;
        end
      end
      S_TOUT: begin
        alu_req = '{op: ALU_CMP, a: tick_q, b: turbo_tout_q};
        state_d = alu_rsp.eq ? S_TURBO : S_LOW;
      end
      S_TURBO: begin
        alu_req = '{op: ALU_CMP, a: chosen_lvl_q, b: turbo_lvl_q};
        state_d = alu_rsp.eq ? S_TMARK : S_LOW;
      end
      S_TMARK: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '{drive_level: cur_q, store_valid: 1'b1,
                          store_value: TURBO_MARK | {4'd0, chosen_idx_q},
                          blank: 1'b0, shut_off: 1'b0, last: 1'b0};
          state_d     = S_RAMP;
        end
      end
      S_RAMP: begin
        // step down while the level is above the stepdown level
        alu_req = '{op: ALU_DEC, a: cur_q, b: stepdown_q};
        if (alu_rsp.lt || alu_rsp.eq) begin
          state_d = S_LOW;
        end else if (slot_free) begin
          cur_d       = alu_rsp.res;
          out_valid_d = 1'b1;
          out_item_d  = '{drive_level: alu_rsp.res, store_valid: 1'b0, store_value: 8'd0,
                          blank: 1'b0, shut_off: 1'b0, last: 1'b0};
        end
      end
      S_LOW: begin
        alu_req = '{op: ALU_CMP, a: sample_q, b: at_min_q ? crit_thr_q : low_thr_q};
        if (alu_rsp.lt) begin
          state_d = S_RUN;
        end else begin
          low_run_d = 4'd0;
          state_d   = S_FINAL;
        end
      end
      S_RUN: begin
        alu_req = '{op: ALU_CMP, a: {4'd0, low_run_q}, b: {4'd0, run_limit_q}};
        if (!alu_rsp.lt) begin
          low_run_d = 4'd0;
          state_d   = at_min_q ? S_OFF : S_HALF;
        end else begin
          low_run_d = low_run_q + 4'd1;
          state_d   = S_FINAL;
        end
      end
      S_HALF: begin
        alu_req = '{op: ALU_HALF, a: cur_q, b: min_lvl_q};
        cur_d   = alu_rsp.res;
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        // clamp the halved level at the minimum
        alu_req = '{op: ALU_CMP, a: cur_q, b: min_lvl_q};
        if (slot_free) begin
          if (alu_rsp.lt) begin
            cur_d    = min_lvl_q;
            at_min_d = 1'b1;
          end
          out_valid_d = 1'b1;
          out_item_d  = '{drive_level: cur_d, store_valid: 1'b0, store_value: 8'd0,
                          blank: 1'b1, shut_off: 1'b0, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_OFF: begin
        if (slot_free) begin
          cur_d       = 8'd0;
          halted_d    = 1'b1;
          out_valid_d = 1'b1;
          out_item_d  = '{drive_level: 8'd0, store_valid: 1'b0, store_value: 8'd0,
                          blank: 1'b0, shut_off: 1'b1, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '{drive_level: cur_q, store_valid: 1'b0, store_value: 8'd0,
                          blank: 1'b0, shut_off: 1'b0, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      turbo_lvl_q  <= 8'd252;
      stepdown_q   <= 8'd200;
      store_dly_q  <= 8'd6;
      turbo_tout_q <= 8'd120;
      low_thr_q    <= 8'd125;
      crit_thr_q   <= 8'd120;
      min_lvl_q    <= 8'd7;
      run_limit_q  <= 4'd8;
      tick_q       <= 8'd0;
      low_run_q    <= 4'd0;
      at_min_q     <= 1'b0;
      cur_q        <= 8'd0;
      chosen_lvl_q <= 8'd0;
      chosen_idx_q <= 4'd0;
      halted_q     <= 1'b0;
      sample_q     <= 8'd0;
      out_valid_q  <= 1'b0;
      out_item_q   <= '0;
    end else begin
      state_q      <= state_d;
      tick_q       <= tick_d;
      low_run_q    <= low_run_d;
      at_min_q     <= at_min_d;
      cur_q        <= cur_d;
      chosen_lvl_q <= chosen_lvl_d;
      chosen_idx_q <= chosen_idx_d;
      halted_q     <= halted_d;
      sample_q     <= sample_d;
      out_valid_q  <= out_valid_d;
      out_item_q   <= out_item_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TURBO_LEVEL:   turbo_lvl_q  <= cfg_data_i;
          CFG_STEPDOWN:      stepdown_q   <= cfg_data_i;
          CFG_STORE_DELAY:   store_dly_q  <= cfg_data_i;
          CFG_TURBO_TIMEOUT: turbo_tout_q <= cfg_data_i;
          CFG_LOW_THR:       low_thr_q    <= cfg_data_i;
          CFG_CRIT_THR:      crit_thr_q   <= cfg_data_i;
          CFG_MIN_LEVEL:     min_lvl_q    <= cfg_data_i;
          CFG_LOW_RUN_LIMIT: run_limit_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: test/light_level_tick_supervisor_unit_test.sv
// ----------------------------------------------------------------------------
// light_level_tick_supervisor_unit_test: self-checking bench of the supervisor
// Drives start and tick items through the valid/stall input channel, predicts
// every result item from a bench copy of the registers and state, and compares
// each accepted result field by field. Directed tests cover start levels,
// store timing, the turbo ramp, low battery halving and shut-off; random
// phases follow with varied settings, sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module light_level_tick_supervisor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import llts_pkg::*;

  localparam int unsigned STALL_NONE   = 0;
  localparam int unsigned STALL_RANDOM = 1;
  localparam int unsigned STALL_SHORT  = 2;
  localparam int unsigned STALL_LONG   = 3;

  localparam int unsigned PICK_LOW  = 0;
  localparam int unsigned PICK_HIGH = 1;
  localparam int unsigned PICK_ANY  = 2;

  localparam int unsigned IN_W = $bits(in_item_t);

  logic                 clk         = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i  = '0;

  // bench copy of the registers
  logic [7:0] reg_turbo_level, reg_stepdown, reg_store_delay, reg_turbo_timeout;
  logic [7:0] reg_low_thr, reg_crit_thr, reg_min_level;
  logic [3:0] reg_low_run_limit;

  // bench copy of the supervisor state
  logic [7:0] sup_ticks, sup_level, sup_chosen_level;
  logic [3:0] sup_low_run, sup_chosen_index;
  logic       sup_at_min, sup_halted;

  out_item_t   drive_results_q[$];
  out_item_t   want_item;
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  bit          idle_on        = 1'b0;
  int unsigned stall_style    = STALL_NONE;
  int unsigned stall_phase    = 0;

  light_level_tick_supervisor_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_style)
      STALL_RANDOM: out_stall_i <= ($urandom_range(0, 99) < 40);
      STALL_SHORT:  out_stall_i <= ((stall_phase % 5) < 2);
      STALL_LONG:   out_stall_i <= ((stall_phase % 29) < 20);
      default:      out_stall_i <= 1'b0;
    endcase
  end

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
  endfunction

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_results_q.size() == 0) begin
        note_mismatch("unexpected result item", 0, 32'(out_item_o));
      end else begin
        want_item = drive_results_q.pop_front();
        if (out_item_o.drive_level !== want_item.drive_level)
          note_mismatch("drive_level", 32'(want_item.drive_level),
                        32'(out_item_o.drive_level));
        if (out_item_o.store_valid !== want_item.store_valid)
          note_mismatch("store_valid", 32'(want_item.store_valid),
                        32'(out_item_o.store_valid));
        if (out_item_o.store_value !== want_item.store_value)
          note_mismatch("store_value", 32'(want_item.store_value),
                        32'(out_item_o.store_value));
        if (out_item_o.blank !== want_item.blank)
          note_mismatch("blank", 32'(want_item.blank), 32'(out_item_o.blank));
        if (out_item_o.shut_off !== want_item.shut_off)
          note_mismatch("shut_off", 32'(want_item.shut_off), 32'(out_item_o.shut_off));
        if (out_item_o.last !== want_item.last)
          note_mismatch("last", 32'(want_item.last), 32'(out_item_o.last));
      end
    end
  end

  function automatic void reset_supervisor();
    reg_turbo_level   = 8'd252;
    reg_stepdown      = 8'd200;
    reg_store_delay   = 8'd6;
    reg_turbo_timeout = 8'd120;
    reg_low_thr       = 8'd125;
    reg_crit_thr      = 8'd120;
    reg_min_level     = 8'd7;
    reg_low_run_limit = 4'd8;
    sup_ticks         = '0;
    sup_low_run       = '0;
    sup_at_min        = 1'b0;
    sup_level         = '0;
    sup_chosen_level  = '0;
    sup_chosen_index  = '0;
    sup_halted        = 1'b0;
  endfunction

  function automatic void add_level_result(logic [7:0] lvl, logic sv, logic [7:0] sval,
                                           logic bl, logic off, logic fin);
    out_item_t r;
    r.drive_level = lvl;
    r.store_valid = sv;
    r.store_value = sval;
    r.blank       = bl;
    r.shut_off    = off;
    r.last        = fin;
    drive_results_q.push_back(r);
  endfunction

  // work out the result items of one accepted item and advance the state
  function automatic void predict_drive_levels(in_item_t it);
    logic low_sample;
    logic fire;
    fire = 1'b0;
    if (it.command == CMD_START) begin
      sup_chosen_index = it.mode_index;
      sup_chosen_level = it.nominal_level;
      sup_level   = (sup_chosen_level < reg_min_level) ? FULL_LEVEL : sup_chosen_level;
      sup_ticks   = '0;
      sup_low_run = '0;
      sup_at_min  = 1'b0;
      sup_halted  = 1'b0;
      add_level_result(sup_level, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
    end else if (sup_halted) begin
      add_level_result(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
    end else begin
      if (sup_ticks != TICK_MAX) sup_ticks = sup_ticks + 8'd1;
      if (sup_ticks == reg_store_delay) begin
        add_level_result(sup_level, 1'b1, {4'h0, sup_chosen_index}, 1'b0, 1'b0, 1'b0);
      end else if (sup_ticks == reg_turbo_timeout && sup_chosen_level == reg_turbo_level) begin
        add_level_result(sup_level, 1'b1, TURBO_MARK | {4'h0, sup_chosen_index},
                         1'b0, 1'b0, 1'b0);
        while (sup_level > reg_stepdown) begin
          sup_level = sup_level - 8'd1;
          add_level_result(sup_level, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        end
      end
      low_sample = sup_at_min ? (it.battery_sample < reg_crit_thr)
                              : (it.battery_sample < reg_low_thr);
      if (low_sample) begin
        if (sup_low_run >= reg_low_run_limit) begin
          sup_low_run = '0;
          fire = 1'b1;
        end else begin
          sup_low_run = sup_low_run + 4'd1;
        end
      end else begin
        sup_low_run = '0;
      end
      if (fire && sup_at_min) begin
        sup_level  = '0;
        sup_halted = 1'b1;
        add_level_result(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
      end else if (fire) begin
        sup_level = sup_level >> 1;
        if (sup_level < reg_min_level) begin
          sup_level  = reg_min_level;
          sup_at_min = 1'b1;
        end
        add_level_result(sup_level, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1);
      end else begin
        add_level_result(sup_level, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
      end
    end
  endfunction

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_TURBO_LEVEL:   reg_turbo_level   = val;
      CFG_STEPDOWN:      reg_stepdown      = val;
      CFG_STORE_DELAY:   reg_store_delay   = val;
      CFG_TURBO_TIMEOUT: reg_turbo_timeout = val;
      CFG_LOW_THR:       reg_low_thr       = val;
      CFG_CRIT_THR:      reg_crit_thr      = val;
      CFG_MIN_LEVEL:     reg_min_level     = val;
      CFG_LOW_RUN_LIMIT: reg_low_run_limit = val[3:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [7:0] turbo, input logic [7:0] stepdown,
                           input logic [7:0] store_dly, input logic [7:0] timeout,
                           input logic [7:0] low_thr, input logic [7:0] crit_thr,
                           input logic [7:0] min_lvl, input logic [3:0] run_limit);
    set_reg(CFG_TURBO_LEVEL, turbo);
    set_reg(CFG_STEPDOWN, stepdown);
    set_reg(CFG_STORE_DELAY, store_dly);
    set_reg(CFG_TURBO_TIMEOUT, timeout);
    set_reg(CFG_LOW_THR, low_thr);
    set_reg(CFG_CRIT_THR, crit_thr);
    set_reg(CFG_MIN_LEVEL, min_lvl);
    set_reg(CFG_LOW_RUN_LIMIT, {4'h0, run_limit});
  endtask

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = idle_on ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk); while (in_stall_o);
    predict_drive_levels(it);
  endtask

  task automatic send_start(input logic [3:0] idx, input logic [7:0] nominal);
    in_item_t it;
    it.command        = CMD_START;
    it.mode_index     = idx;
    it.nominal_level  = nominal;
    it.battery_sample = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic send_tick(input logic [7:0] sample);
    in_item_t it;
    it.command        = CMD_TICK;
    it.mode_index     = 4'($urandom_range(0, 15));
    it.nominal_level  = 8'($urandom_range(0, 255));
    it.battery_sample = sample;
    send_item(it);
  endtask

  // drop valid and hold until every predicted result has come out
  task automatic settle();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (drive_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic test_tick_before_start();
    send_tick(8'hff);
    send_tick(8'h00);
    settle();
  endtask

  task automatic test_start_levels();
    send_start(4'h0, 8'h00);
    send_start(4'hf, 8'h06);
    send_start(4'ha, 8'h07);
    settle();
  endtask

  task automatic test_store_timing();
    // equal tick counts: the plain store wins
    load_regs(8'd255, 8'd196, 8'd2, 8'd2, 8'd0, 8'd0, 8'd7, 4'd8);
    send_start(4'h9, 8'hff);
    repeat (3) send_tick(8'($urandom_range(0, 255)));
    settle();
    // full turbo ramp from full level down to the lowest stepdown level
    load_regs(8'd255, 8'd196, 8'd1, 8'd2, 8'd0, 8'd0, 8'd7, 4'd8);
    send_start(4'h6, 8'hff);
    repeat (2) send_tick(8'($urandom_range(0, 255)));
    settle();
  endtask

  task automatic test_ramp_already_low();
    load_regs(8'd200, 8'd255, 8'd1, 8'd2, 8'd0, 8'd0, 8'd7, 4'd8);
    send_start(4'hc, 8'd200);
    repeat (2) send_tick(8'($urandom_range(0, 255)));
    settle();
  endtask

  task automatic test_low_battery();
    // limit zero: every low sample halves at once, then critical shuts off
    load_regs(8'd252, 8'd200, 8'd254, 8'd254, 8'd255, 8'd255, 8'd100, 4'd0);
    send_start(4'h1, 8'hff);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'hfe);
    send_tick(8'h00);
    send_start(4'h2, 8'd50);
    settle();
  endtask

  task automatic test_low_run_count();
    load_regs(8'd252, 8'd200, 8'd254, 8'd254, 8'd128, 8'd0, 8'd1, 4'd2);
    send_start(4'h3, 8'hff);
    send_tick(8'h7f);
    send_tick(8'h7f);
    send_tick(8'h80);
    repeat (3) send_tick(8'h7f);
    settle();
  endtask

  task automatic test_min_level_zero();
    load_regs(8'd252, 8'd200, 8'd254, 8'd254, 8'd255, 8'd255, 8'd0, 4'd0);
    send_start(4'h7, 8'h00);
    send_tick(8'h00);
    send_tick(8'h00);
    settle();
  endtask

  function automatic logic [7:0] pick_value(int unsigned lo, int unsigned hi,
                                            int unsigned how);
    if (how == PICK_LOW) return lo[7:0];
    if (how == PICK_HIGH) return hi[7:0];
    case ($urandom_range(0, 3))
      0:       return lo[7:0];
      1:       return hi[7:0];
      default: return 8'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [7:0] pick_ticks(int unsigned how);
    if (how != PICK_ANY || $urandom_range(0, 4) == 0) return pick_value(1, 254, how);
    return 8'($urandom_range(1, 10));
  endfunction

  function automatic logic [7:0] battery_for_state();
    logic [7:0] thr;
    thr = sup_at_min ? reg_crit_thr : reg_low_thr;
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      3:       return 8'($urandom_range(thr, 255));
      default: return (thr == 0) ? 8'h00 : 8'($urandom_range(0, thr - 1));
    endcase
  endfunction

  task automatic test_random_sequences();
    in_item_t    stray;
    int unsigned sent;
    int unsigned how;
    int unsigned n_ticks;
    logic [7:0]  nominal;
    for (int unsigned phase = 0; phase < 6; phase++) begin
      how = (phase < 2) ? phase : PICK_ANY;
      load_regs(pick_value(196, 255, how), pick_value(196, 255, how), pick_ticks(how),
                pick_ticks(how), pick_value(0, 255, how), pick_value(0, 255, how),
                pick_value(1, 255, how), 4'(pick_value(1, 15, how)));
      stall_style = phase % 4;
      idle_on     = (phase % 3) != 0;
      sent = 0;
      while (sent < 17) begin
        if ($urandom_range(0, 9) == 0) begin
          stray = in_item_t'(IN_W'($urandom));
          send_item(stray);
          sent++;
        end else begin
          case ($urandom_range(0, 3))
            0:       nominal = reg_turbo_level;
            1:       nominal = 8'($urandom_range(0, reg_min_level));
            default: nominal = 8'($urandom_range(0, 255));
          endcase
          send_start(4'($urandom_range(0, 15)), nominal);
          n_ticks = $urandom_range(1, 14);
          repeat (n_ticks) send_tick(battery_for_state());
          sent += n_ticks + 1;
        end
      end
      settle();
    end
  endtask

  initial begin
    reset_supervisor();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    test_tick_before_start();
    test_start_levels();
    test_store_timing();
    test_ramp_already_low();
    test_low_battery();
    test_low_run_count();
    test_min_level_zero();
    test_random_sequences();
    settle();
    if (mismatch_count == 0 && drive_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
